// File: src/cbtf_pkg.sv
// Package for the cascaded boxcar tone filter: sizes, register indexes, controller
// states, the command word between controller and datapath, and length clamping.
// Depends on nothing; every other design file but cbtf_ram refers to it by scoped names.
`default_nettype none

package cbtf_pkg;

  // Both history depths are powers of two so that the circular indexes wrap freely.
  localparam int HISTORY_DEPTH  = 2048;
  localparam int TREND_DEPTH    = 64;
  localparam int SAMPLE_BITS    = 24;

  localparam int HIST_AW        = $clog2(HISTORY_DEPTH);
  localparam int HIST_CNT_BITS  = HIST_AW + 1;
  localparam int TREND_AW       = $clog2(TREND_DEPTH);
  localparam int TREND_CNT_BITS = TREND_AW + 1;

  localparam int LONG_LEN_BITS  = 12;
  localparam int TREND_LEN_BITS = 7;
  localparam int RECIP_BITS     = 25;
  localparam int RECIP_SPLIT    = 12;
  localparam int RECIP_FRAC     = 24;
  localparam int MIX_BITS       = 16;
  localparam int MIX_FRAC       = 15;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 25;

  localparam int SUM_BITS       = SAMPLE_BITS + HIST_AW + 1;
  localparam int TREND_BITS     = SAMPLE_BITS + 2;
  localparam int TREND_SUM_BITS = TREND_BITS + TREND_AW + 1;
  localparam int AVG_BITS       = SUM_BITS + 2;
  localparam int TDIFF_BITS     = AVG_BITS + 2;
  localparam int MUL_A_BITS     = AVG_BITS;
  localparam int MUL_B_BITS     = MIX_BITS;
  localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS + 1;
  localparam int ACC_BITS       = 64;

  localparam logic [RECIP_BITS-1:0] RECIP_ONE = RECIP_BITS'(1) << RECIP_FRAC;
  localparam logic [MIX_BITS-1:0]   MIX_ONE   = MIX_BITS'(1) << MIX_FRAC;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_LENGTH      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TREND_LENGTH     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_RECIPROCAL  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_RECIPROCAL = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TREND_RECIPROCAL = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TONE_MIX         = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LONG,
    ST_RD_SHORT,
    ST_LONG_LO,
    ST_LONG_HI,
    ST_SHORT_LO,
    ST_SHORT_HI,
    ST_TREND_PUT,
    ST_TREND_UPD,
    ST_TREND_LO,
    ST_TREND_HI,
    ST_MIX_DRY,
    ST_MIX_TONE,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LONG_LO,
    MUL_LONG_HI,
    MUL_SHORT_LO,
    MUL_SHORT_HI,
    MUL_TREND_LO,
    MUL_TREND_HI,
    MUL_DRY,
    MUL_TONE
  } mul_op_t;

  typedef enum logic [1:0] {
    AVG_NONE,
    AVG_LONG,
    AVG_SHORT,
    AVG_TREND
  } avg_sel_t;

  typedef struct packed {
    logic     take_in;
    logic     hist_rd_long;
    logic     hist_upd_long;
    logic     hist_rd_short;
    logic     hist_upd_short;
    logic     trend_rd;
    logic     trend_upd;
    mul_op_t  mul_op;
    logic     acc_load;
    avg_sel_t avg_sel;
    logic     out_load;
  } cmd_t;

  // A length of zero acts as one; a length above the depth acts as the depth.
  function automatic logic [HIST_CNT_BITS-1:0] clamp_hist(input logic [LONG_LEN_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      return HIST_CNT_BITS'(1);
    end else if (w > 32'(HISTORY_DEPTH)) begin
      return HIST_CNT_BITS'(HISTORY_DEPTH);
    end
    return HIST_CNT_BITS'(w);
  endfunction

  function automatic logic [TREND_CNT_BITS-1:0] clamp_trend(
    input logic [TREND_LEN_BITS-1:0] v
  );
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      return TREND_CNT_BITS'(1);
    end else if (w > 32'(TREND_DEPTH)) begin
      return TREND_CNT_BITS'(TREND_DEPTH);
    end
    return TREND_CNT_BITS'(w);
  endfunction

endpackage

`default_nettype wire

// File: src/cbtf_if.sv
// Channel interfaces of the cascaded boxcar tone filter: sample input, result output
// and configuration write. Each carries valid, ready and its payload; uses cbtf_pkg.
`default_nettype none

interface cbtf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cbtf_pkg::SAMPLE_BITS-1:0] in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

interface cbtf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cbtf_pkg::SAMPLE_BITS-1:0] out_sample;
  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

interface cbtf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [cbtf_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [cbtf_pkg::CFG_DATA_BITS-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/cascaded_boxcar_tone_filter.sv
// Cascaded boxcar tone filter, top level: joins the sequencing controller and the
// datapath. Uses cbtf_pkg, the channel interfaces, cbtf_ctrl and cbtf_dp.
//
// Channels: audio carries one signed sample per request, result carries one
// filtered sample per request, and cfg writes one register (index, data) per
// request. A request moves at a rising edge of clk with valid and ready high.
// Configuration is taken in any cycle; it is meant to be written while no sample
// is in flight. A length write empties both histories and their running sums.
// A new sample is accepted only after the previous one has left the final step; the
// pace is set by the two reads through the single read port of the sample history
// and the eight passes through the one shared multiplier.
// The next sample may be accepted while the previous result still waits; if the
// receiver stalls, the block holds the finished sample in its last step until
// the result register is free.
// Reset (rst, synchronous, active high): lengths one, reciprocals one, tone zero,
// histories empty. Emptiness is kept by fill counts, so no clearing pass runs and
// the block accepts a sample in the first cycle after reset.
`default_nettype none

module cascaded_boxcar_tone_filter (
  input  wire logic    clk,
  input  wire logic    rst,
  cbtf_in_if.sink      audio,
  cbtf_out_if.source   result,
  cbtf_cfg_if.sink     cfg
);

  cbtf_pkg::cmd_t cmd;
  logic           cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  cbtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (audio.valid),
    .in_ready  (audio.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  cbtf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_sample  (audio.in_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_sample (result.out_sample)
  );

endmodule

`default_nettype wire

// File: src/cbtf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for both histories of the tone filter; depends on nothing.
`default_nettype none

module cbtf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/cbtf_ctrl.sv
// Sequencing controller of the tone filter: walks one sample through history reads,
// the shared multiplier passes and the output register. Uses cbtf_pkg.
`default_nettype none

module cbtf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cbtf_pkg::cmd_t     cmd
);

  cbtf_pkg::state_t state;
  cbtf_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbtf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      cbtf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in      = 1'b1;
          cmd.hist_rd_long = 1'b1;
          state_next       = cbtf_pkg::ST_RD_LONG;
        end
      end
      cbtf_pkg::ST_RD_LONG: begin
        cmd.hist_upd_long = 1'b1;
        cmd.hist_rd_short = 1'b1;
        cmd.trend_rd      = 1'b1;
        state_next        = cbtf_pkg::ST_RD_SHORT;
      end
      cbtf_pkg::ST_RD_SHORT: begin
        cmd.hist_upd_short = 1'b1;
        state_next         = cbtf_pkg::ST_LONG_LO;
      end
      cbtf_pkg::ST_LONG_LO: begin
        cmd.mul_op = cbtf_pkg::MUL_LONG_LO;
        state_next = cbtf_pkg::ST_LONG_HI;
      end
      cbtf_pkg::ST_LONG_HI: begin
        cmd.mul_op   = cbtf_pkg::MUL_LONG_HI;
        cmd.acc_load = 1'b1;
        state_next   = cbtf_pkg::ST_SHORT_LO;
      end
      cbtf_pkg::ST_SHORT_LO: begin
        cmd.mul_op  = cbtf_pkg::MUL_SHORT_LO;
        cmd.avg_sel = cbtf_pkg::AVG_LONG;
        state_next  = cbtf_pkg::ST_SHORT_HI;
      end
      cbtf_pkg::ST_SHORT_HI: begin
        cmd.mul_op   = cbtf_pkg::MUL_SHORT_HI;
        cmd.acc_load = 1'b1;
        state_next   = cbtf_pkg::ST_TREND_PUT;
      end
      cbtf_pkg::ST_TREND_PUT: begin
        cmd.avg_sel = cbtf_pkg::AVG_SHORT;
        state_next  = cbtf_pkg::ST_TREND_UPD;
      end
      cbtf_pkg::ST_TREND_UPD: begin
        cmd.trend_upd = 1'b1;
        state_next    = cbtf_pkg::ST_TREND_LO;
      end
      cbtf_pkg::ST_TREND_LO: begin
        cmd.mul_op = cbtf_pkg::MUL_TREND_LO;
        state_next = cbtf_pkg::ST_TREND_HI;
      end
      cbtf_pkg::ST_TREND_HI: begin
        cmd.mul_op   = cbtf_pkg::MUL_TREND_HI;
        cmd.acc_load = 1'b1;
        state_next   = cbtf_pkg::ST_MIX_DRY;
      end
      cbtf_pkg::ST_MIX_DRY: begin
        // The dry term does not need the trend average, so it overlaps its completion.
        cmd.mul_op  = cbtf_pkg::MUL_DRY;
        cmd.avg_sel = cbtf_pkg::AVG_TREND;
        state_next  = cbtf_pkg::ST_MIX_TONE;
      end
      cbtf_pkg::ST_MIX_TONE: begin
        cmd.mul_op   = cbtf_pkg::MUL_TONE;
        cmd.acc_load = 1'b1;
        state_next   = cbtf_pkg::ST_FINISH;
      end
      cbtf_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = cbtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == cbtf_pkg::ST_RD_LONG))
    else $error("accepted request did not start the history reads");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result still waits");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == cbtf_pkg::ST_FINISH))
    else $error("result appeared outside the final step");

endmodule

`default_nettype wire

// File: src/cbtf_dp.sv
// Datapath of the tone filter: configuration registers, both histories and running
// sums, the shared multiplier with its accumulator, and the output register.
// Uses cbtf_pkg and cbtf_ram; driven by commands from cbtf_ctrl.
`default_nettype none

module cbtf_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire cbtf_pkg::cmd_t                           cmd,
  input  wire logic signed [cbtf_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  wire logic                                     cfg_we,
  input  wire logic [cbtf_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  wire logic [cbtf_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  output logic signed [cbtf_pkg::SAMPLE_BITS-1:0]       out_sample
);

  localparam int SB   = cbtf_pkg::SAMPLE_BITS;
  localparam int HAW  = cbtf_pkg::HIST_AW;
  localparam int HCB  = cbtf_pkg::HIST_CNT_BITS;
  localparam int TAW  = cbtf_pkg::TREND_AW;
  localparam int TCB  = cbtf_pkg::TREND_CNT_BITS;
  localparam int SUMB = cbtf_pkg::SUM_BITS;
  localparam int TB   = cbtf_pkg::TREND_BITS;
  localparam int TSB  = cbtf_pkg::TREND_SUM_BITS;
  localparam int AB   = cbtf_pkg::AVG_BITS;
  localparam int DB   = cbtf_pkg::TDIFF_BITS;
  localparam int MAB  = cbtf_pkg::MUL_A_BITS;
  localparam int MBB  = cbtf_pkg::MUL_B_BITS;
  localparam int PB   = cbtf_pkg::PROD_BITS;
  localparam int ACB  = cbtf_pkg::ACC_BITS;
  localparam int RS   = cbtf_pkg::RECIP_SPLIT;
  localparam int RF   = cbtf_pkg::RECIP_FRAC;
  localparam int RB   = cbtf_pkg::RECIP_BITS;
  localparam int XB   = cbtf_pkg::MIX_BITS;

  localparam logic signed [DB-1:0]  TREND_MAX  = DB'((64'sd1 <<< (TB - 1)) - 64'sd1);
  localparam logic signed [DB-1:0]  TREND_MIN  = -TREND_MAX - DB'(1);
  localparam logic signed [ACB-1:0] SAMPLE_MAX = ACB'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [ACB-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACB'(1);

  // Configuration registers
  logic        [cbtf_pkg::LONG_LEN_BITS-1:0]  long_length;
  logic        [cbtf_pkg::LONG_LEN_BITS-1:0]  short_length;
  logic        [cbtf_pkg::TREND_LEN_BITS-1:0] trend_length;
  logic        [RB-1:0]                       long_reciprocal;
  logic        [RB-1:0]                       short_reciprocal;
  logic        [RB-1:0]                       trend_reciprocal;
  logic signed [XB-1:0]                       tone_mix;

  // Filter state
  logic        [HAW-1:0]  history_index;
  logic        [HCB-1:0]  hist_fill;
  logic signed [SUMB-1:0] long_sum;
  logic signed [SUMB-1:0] short_sum;
  logic        [TAW-1:0]  trend_index;
  logic        [TCB-1:0]  trend_fill;
  logic signed [TSB-1:0]  trend_sum;

  // Working registers for one sample
  logic signed [SB-1:0]   dry;
  logic signed [PB-1:0]   prod;
  logic signed [ACB-1:0]  acc;
  logic signed [AB-1:0]   long_avg;
  logic signed [AB-1:0]   short_avg;
  logic signed [AB-1:0]   trend_avg;

  logic        [HCB-1:0]  sl_c;
  logic        [HCB-1:0]  ll_c;
  logic        [HCB-1:0]  ll_eff;
  logic        [TCB-1:0]  tl_c;
  logic                   length_wr;

  logic        [HAW-1:0]  hist_rd_addr;
  logic        [SB-1:0]   hist_rd_data;
  logic                   hist_drop_ok;
  logic signed [SUMB-1:0] hist_drop;
  logic signed [SUMB-1:0] hist_sum_sel;
  logic signed [SUMB-1:0] hist_sum_new;

  logic        [TB-1:0]   trend_rd_data;
  logic signed [TSB-1:0]  trend_drop;
  logic signed [DB-1:0]   trend_diff;
  logic signed [TB-1:0]   trend_value;

  logic        [XB-1:0]   tone_k;
  logic        [XB-1:0]   tone_rest;
  logic signed [MAB-1:0]  mix_x;
  logic signed [MAB-1:0]  mul_a;
  logic        [MBB-1:0]  mul_b;
  logic signed [ACB-1:0]  prod_ext;
  logic signed [ACB-1:0]  fin_sum;
  logic signed [AB-1:0]   fin_avg;
  logic signed [ACB-1:0]  mix_sum;
  logic signed [ACB-1:0]  mix_shr;
  logic signed [SB-1:0]   mix_sat;

  assign sl_c   = cbtf_pkg::clamp_hist(short_length);
  assign ll_c   = cbtf_pkg::clamp_hist(long_length);
  assign ll_eff = (sl_c > ll_c) ? sl_c : ll_c;
  assign tl_c   = cbtf_pkg::clamp_trend(trend_length);

  assign length_wr = cfg_we && (cfg_index == cbtf_pkg::REG_LONG_LENGTH ||
                                cfg_index == cbtf_pkg::REG_SHORT_LENGTH ||
                                cfg_index == cbtf_pkg::REG_TREND_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_length      <= cbtf_pkg::LONG_LEN_BITS'(1);
      short_length     <= cbtf_pkg::LONG_LEN_BITS'(1);
      trend_length     <= cbtf_pkg::TREND_LEN_BITS'(1);
      long_reciprocal  <= cbtf_pkg::RECIP_ONE;
      short_reciprocal <= cbtf_pkg::RECIP_ONE;
      trend_reciprocal <= cbtf_pkg::RECIP_ONE;
      tone_mix         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbtf_pkg::REG_LONG_LENGTH:      long_length <= cfg_data[cbtf_pkg::LONG_LEN_BITS-1:0];
        cbtf_pkg::REG_SHORT_LENGTH:     short_length <= cfg_data[cbtf_pkg::LONG_LEN_BITS-1:0];
        cbtf_pkg::REG_TREND_LENGTH:     trend_length <= cfg_data[cbtf_pkg::TREND_LEN_BITS-1:0];
        cbtf_pkg::REG_LONG_RECIPROCAL:  long_reciprocal <= cfg_data[RB-1:0];
        cbtf_pkg::REG_SHORT_RECIPROCAL: short_reciprocal <= cfg_data[RB-1:0];
        cbtf_pkg::REG_TREND_RECIPROCAL: trend_reciprocal <= cfg_data[RB-1:0];
        cbtf_pkg::REG_TONE_MIX:         tone_mix <= $signed(cfg_data[XB-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Sample history. The fill count stands in for clearing the memory: an entry
  // older than the fill count was never written since the last clear and reads as zero.
  assign hist_rd_addr = cmd.hist_rd_short ? (history_index - sl_c[HAW-1:0])
                                          : (history_index - ll_eff[HAW-1:0]);

  cbtf_ram #(
    .WIDTH (SB),
    .DEPTH (cbtf_pkg::HISTORY_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (cmd.hist_upd_short),
    .wr_addr (history_index),
    .wr_data (dry),
    .rd_en   (cmd.hist_rd_long || cmd.hist_rd_short),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data)
  );

  assign hist_drop_ok = cmd.hist_upd_long ? (hist_fill >= ll_eff) : (hist_fill >= sl_c);
  assign hist_drop    = hist_drop_ok ? SUMB'($signed(hist_rd_data)) : '0;
  assign hist_sum_sel = cmd.hist_upd_long ? long_sum : short_sum;
  assign hist_sum_new = hist_sum_sel - hist_drop + SUMB'(dry);

  always_ff @(posedge clk) begin
    if (rst || length_wr) begin
      history_index <= '0;
      hist_fill     <= '0;
      long_sum      <= '0;
      short_sum     <= '0;
    end else begin
      if (cmd.hist_upd_long) begin
        long_sum <= hist_sum_new;
      end
      if (cmd.hist_upd_short) begin
        short_sum     <= hist_sum_new;
        history_index <= history_index + HAW'(1);
        if (hist_fill != HCB'(cbtf_pkg::HISTORY_DEPTH)) begin
          hist_fill <= hist_fill + HCB'(1);
        end
      end
    end
  end

  // Trend history
  cbtf_ram #(
    .WIDTH (TB),
    .DEPTH (cbtf_pkg::TREND_DEPTH)
  ) u_trend_ram (
    .clk     (clk),
    .wr_en   (cmd.trend_upd),
    .wr_addr (trend_index),
    .wr_data (trend_value),
    .rd_en   (cmd.trend_rd),
    .rd_addr (trend_index - tl_c[TAW-1:0]),
    .rd_data (trend_rd_data)
  );

  assign trend_diff = (DB'(short_avg) <<< 1) - DB'(long_avg);

  always_comb begin
    if (trend_diff > TREND_MAX) begin
      trend_value = TREND_MAX[TB-1:0];
    end else if (trend_diff < TREND_MIN) begin
      trend_value = TREND_MIN[TB-1:0];
    end else begin
      trend_value = trend_diff[TB-1:0];
    end
  end

  assign trend_drop = (trend_fill >= tl_c) ? TSB'($signed(trend_rd_data)) : '0;

  always_ff @(posedge clk) begin
    if (rst || length_wr) begin
      trend_index <= '0;
      trend_fill  <= '0;
      trend_sum   <= '0;
    end else if (cmd.trend_upd) begin
      trend_sum   <= trend_sum - trend_drop + TSB'(trend_value);
      trend_index <= trend_index + TAW'(1);
      if (trend_fill != TCB'(cbtf_pkg::TREND_DEPTH)) begin
        trend_fill <= trend_fill + TCB'(1);
      end
    end
  end

  // Tone blend: with k = |tone_mix| the result is x*k + dry*(1 - k), where x is
  // the trend average when darkening and dry minus the trend average when brightening.
  assign tone_k    = tone_mix[XB-1] ? (~tone_mix + XB'(1)) : tone_mix;
  assign tone_rest = cbtf_pkg::MIX_ONE - tone_k;
  assign mix_x     = tone_mix[XB-1] ? (MAB'(dry) - trend_avg) : trend_avg;

  // Shared multiplier. A Q1.24 reciprocal is applied in two halves, low then high.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      cbtf_pkg::MUL_NONE: begin
      end
      cbtf_pkg::MUL_LONG_LO: begin
        mul_a = MAB'(long_sum);
        mul_b = MBB'(long_reciprocal[RS-1:0]);
      end
      cbtf_pkg::MUL_LONG_HI: begin
        mul_a = MAB'(long_sum);
        mul_b = MBB'(long_reciprocal[RB-1:RS]);
      end
      cbtf_pkg::MUL_SHORT_LO: begin
        mul_a = MAB'(short_sum);
        mul_b = MBB'(short_reciprocal[RS-1:0]);
      end
      cbtf_pkg::MUL_SHORT_HI: begin
        mul_a = MAB'(short_sum);
        mul_b = MBB'(short_reciprocal[RB-1:RS]);
      end
      cbtf_pkg::MUL_TREND_LO: begin
        mul_a = MAB'(trend_sum);
        mul_b = MBB'(trend_reciprocal[RS-1:0]);
      end
      cbtf_pkg::MUL_TREND_HI: begin
        mul_a = MAB'(trend_sum);
        mul_b = MBB'(trend_reciprocal[RB-1:RS]);
      end
      cbtf_pkg::MUL_DRY: begin
        mul_a = MAB'(dry);
        mul_b = tone_rest;
      end
      cbtf_pkg::MUL_TONE: begin
        mul_a = mix_x;
        mul_b = tone_k;
      end
      default: begin
      end
    endcase
  end

  assign prod_ext = ACB'(prod);
  assign fin_sum  = acc + (prod_ext <<< RS);
  assign fin_avg  = fin_sum[AB+RF-1:RF];
  assign mix_sum  = acc + prod_ext;
  assign mix_shr  = mix_sum >>> cbtf_pkg::MIX_FRAC;

  always_comb begin
    if (mix_shr > SAMPLE_MAX) begin
      mix_sat = SAMPLE_MAX[SB-1:0];
    end else if (mix_shr < SAMPLE_MIN) begin
      mix_sat = SAMPLE_MIN[SB-1:0];
    end else begin
      mix_sat = mix_shr[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      dry <= in_sample;
    end
    if (cmd.mul_op != cbtf_pkg::MUL_NONE) begin
      prod <= mul_a * $signed({1'b0, mul_b});
    end
    if (cmd.acc_load) begin
      acc <= prod_ext;
    end
    unique case (cmd.avg_sel)
      cbtf_pkg::AVG_NONE:  begin
      end
      cbtf_pkg::AVG_LONG:  long_avg <= fin_avg;
      cbtf_pkg::AVG_SHORT: short_avg <= fin_avg;
      cbtf_pkg::AVG_TREND: trend_avg <= fin_avg;
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      out_sample <= mix_sat;
    end
  end

  a_length_clears: assert property (@(posedge clk) disable iff (rst)
    length_wr |=> (long_sum == '0 && short_sum == '0 && trend_sum == '0 &&
                   hist_fill == '0 && trend_fill == '0))
    else $error("length write did not clear the histories");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    (hist_fill <= HCB'(cbtf_pkg::HISTORY_DEPTH)) &&
    (trend_fill <= TCB'(cbtf_pkg::TREND_DEPTH)))
    else $error("history fill count ran past its depth");

endmodule

`default_nettype wire

// File: tb/cascaded_boxcar_tone_filter_tb.sv
// Self-checking testbench for the cascaded boxcar tone filter: a behavioural model
// predicts every filtered sample from the accepted requests and register writes.
// Depends on cbtf_pkg, the channel interfaces of cbtf_if.sv and the block's top level.

module cascaded_boxcar_tone_filter_tb;
  import cbtf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TREND_BITS-1:0]  trend_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int     IDLE_PERCENT = 7;
  localparam int     STALL_LIMIT  = 5000;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint MIX_UNITY    = longint'(1) << MIX_FRAC;
  localparam logic [RECIP_BITS-1:0] RECIP_MAX = '1;
  localparam logic [MIX_BITS-1:0]   MIX_POS_MAX = 16'h7fff;
  localparam logic [MIX_BITS-1:0]   MIX_NEG_MAX = 16'h8000;
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk;
  logic rst;

  cbtf_in_if  audio_ch ();
  cbtf_out_if result_ch ();
  cbtf_cfg_if cfg_ch ();

  cascaded_boxcar_tone_filter dut (
    .clk    (clk),
    .rst    (rst),
    .audio  (audio_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Model copy of the registers and the filter state.
  logic [LONG_LEN_BITS-1:0]  long_len_reg;
  logic [LONG_LEN_BITS-1:0]  short_len_reg;
  logic [TREND_LEN_BITS-1:0] trend_len_reg;
  logic [RECIP_BITS-1:0]     long_recip_reg;
  logic [RECIP_BITS-1:0]     short_recip_reg;
  logic [RECIP_BITS-1:0]     trend_recip_reg;
  logic signed [MIX_BITS-1:0] tone_reg;

  sample_t sample_store [HISTORY_DEPTH];
  trend_t  trend_store [TREND_DEPTH];
  int      sample_pos;
  int      trend_pos;
  longint  long_acc;
  longint  short_acc;
  longint  trend_acc;

  sample_t expected_out [$];
  sample_t want;
  int      error_count;
  bit      no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_history();
    foreach (sample_store[i]) sample_store[i] = '0;
    foreach (trend_store[i]) trend_store[i] = '0;
    sample_pos = 0;
    trend_pos  = 0;
    long_acc   = 0;
    short_acc  = 0;
    trend_acc  = 0;
  endfunction

  function automatic void reset_model();
    long_len_reg    = 1;
    short_len_reg   = 1;
    trend_len_reg   = 1;
    long_recip_reg  = RECIP_ONE;
    short_recip_reg = RECIP_ONE;
    trend_recip_reg = RECIP_ONE;
    tone_reg        = '0;
    clear_history();
  endfunction

  function automatic int window_len(input int v, input int depth);
    if (v == 0) return 1;
    if (v > depth) return depth;
    return v;
  endfunction

  // Product of sum and Q1.24 reciprocal, floored.
  function automatic longint q24_scale(input longint s, input logic [RECIP_BITS-1:0] r);
    longint rl;
    rl = r;
    return (s * rl) >>> RECIP_FRAC;
  endfunction

  function automatic longint clip(input longint v, input int bits);
    longint top;
    top = (longint'(1) << (bits - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_LONG_LENGTH: begin
        long_len_reg = val[LONG_LEN_BITS-1:0];
        clear_history();
      end
      REG_SHORT_LENGTH: begin
        short_len_reg = val[LONG_LEN_BITS-1:0];
        clear_history();
      end
      REG_TREND_LENGTH: begin
        trend_len_reg = val[TREND_LEN_BITS-1:0];
        clear_history();
      end
      REG_LONG_RECIPROCAL:  long_recip_reg  = val[RECIP_BITS-1:0];
      REG_SHORT_RECIPROCAL: short_recip_reg = val[RECIP_BITS-1:0];
      REG_TREND_RECIPROCAL: trend_recip_reg = val[RECIP_BITS-1:0];
      REG_TONE_MIX:         tone_reg        = val[MIX_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic sample_t filter_sample(input sample_t dry);
    int     short_n;
    int     long_n;
    int     trend_n;
    longint d;
    longint m;
    longint long_avg;
    longint short_avg;
    longint trend_avg;
    longint mixed;
    trend_t trend_val;
    short_n = window_len(short_len_reg, HISTORY_DEPTH);
    long_n  = window_len(long_len_reg, HISTORY_DEPTH);
    trend_n = window_len(trend_len_reg, TREND_DEPTH);
    // A short window longer than the long one stretches the long window to match.
    if (short_n > long_n) long_n = short_n;
    d = dry;
    m = tone_reg;

    long_acc  -= sample_store[(sample_pos + HISTORY_DEPTH - long_n) % HISTORY_DEPTH];
    short_acc -= sample_store[(sample_pos + HISTORY_DEPTH - short_n) % HISTORY_DEPTH];
    sample_store[sample_pos] = dry;
    long_acc  += d;
    short_acc += d;
    sample_pos = (sample_pos + 1) % HISTORY_DEPTH;

    long_avg  = q24_scale(long_acc, long_recip_reg);
    short_avg = q24_scale(short_acc, short_recip_reg);
    trend_val = clip(2 * short_avg - long_avg, TREND_BITS);

    trend_acc -= trend_store[(trend_pos + TREND_DEPTH - trend_n) % TREND_DEPTH];
    trend_store[trend_pos] = trend_val;
    trend_acc += trend_val;
    trend_pos = (trend_pos + 1) % TREND_DEPTH;
    trend_avg = q24_scale(trend_acc, trend_recip_reg);

    if (m >= 0) begin
      mixed = trend_avg * m + d * (MIX_UNITY - m);
    end else begin
      mixed = (d - trend_avg) * (-m) + d * (MIX_UNITY + m);
    end
    return clip(mixed >>> MIX_FRAC, SAMPLE_BITS);
  endfunction

  // Starts and ends at a falling edge; valid stays high for a following request.
  task automatic send_sample(input sample_t s);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      audio_ch.valid     <= 1'b0;
      audio_ch.in_sample <= $urandom;
      @(negedge clk);
    end
    audio_ch.valid     <= 1'b1;
    audio_ch.in_sample <= s;
    do @(posedge clk); while (!audio_ch.ready);
    expected_out.push_back(filter_sample(s));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Registers are only written once every outstanding result has been seen.
  task automatic drain_results();
    audio_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_out.size() != 0);
  endtask

  function automatic sample_t next_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LONG_LEN_BITS-1:0] pick_hist_length();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 4095;
      2:       return HISTORY_DEPTH;
      3:       return $urandom_range(49, 4095);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic logic [RECIP_BITS-1:0] pick_recip(input int n);
    case ($urandom_range(7))
      0:       return '0;
      1:       return RECIP_MAX;
      2:       return $urandom;
      default: return (int'(RECIP_ONE) + n / 2) / n;
    endcase
  endfunction

  function automatic logic [MIX_BITS-1:0] pick_mix();
    case ($urandom_range(5))
      0:       return MIX_POS_MAX;
      1:       return MIX_NEG_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Sometimes sets the unused upper bits of a narrow register write.
  function automatic logic [CFG_DATA_BITS-1:0] with_junk(input logic [CFG_DATA_BITS-1:0] v,
                                                         input int w);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = $urandom;
    if ($urandom_range(3) == 0) return v | (junk << w);
    return v;
  endfunction

  task automatic configure_random(input bit with_lengths);
    int long_n;
    int short_n;
    logic [LONG_LEN_BITS-1:0]  long_v;
    logic [LONG_LEN_BITS-1:0]  short_v;
    logic [TREND_LEN_BITS-1:0] trend_v;
    if (with_lengths) begin
      long_v = pick_hist_length();
      if ($urandom_range(3) == 0) begin
        short_v = pick_hist_length();
      end else begin
        short_v = $urandom_range(1, window_len(long_v, HISTORY_DEPTH));
      end
      if ($urandom_range(3) == 0) begin
        trend_v = $urandom_range(0, 127);
      end else begin
        trend_v = $urandom_range(1, 16);
      end
      write_reg(REG_LONG_LENGTH, with_junk(long_v, LONG_LEN_BITS));
      write_reg(REG_SHORT_LENGTH, with_junk(short_v, LONG_LEN_BITS));
      write_reg(REG_TREND_LENGTH, with_junk(trend_v, TREND_LEN_BITS));
    end
    short_n = window_len(short_len_reg, HISTORY_DEPTH);
    long_n  = window_len(long_len_reg, HISTORY_DEPTH);
    if (short_n > long_n) long_n = short_n;
    write_reg(REG_LONG_RECIPROCAL, pick_recip(long_n));
    write_reg(REG_SHORT_RECIPROCAL, pick_recip(short_n));
    write_reg(REG_TREND_RECIPROCAL, pick_recip(window_len(trend_len_reg, TREND_DEPTH)));
    write_reg(REG_TONE_MIX, with_junk(pick_mix(), MIX_BITS));
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(-1);
    send_sample(1);
    drain_results();
  endtask

  // Zero and oversized lengths, a short window above the long one, the largest
  // and zero reciprocals, full brightening and darkening, a write to the unused index.
  task automatic test_register_extremes();
    write_reg(REG_LONG_LENGTH, 0);
    write_reg(REG_SHORT_LENGTH, 4095);
    write_reg(REG_TREND_LENGTH, 127);
    write_reg(REG_LONG_RECIPROCAL, RECIP_MAX);
    write_reg(REG_SHORT_RECIPROCAL, RECIP_MAX);
    write_reg(REG_TREND_RECIPROCAL, RECIP_MAX);
    write_reg(REG_TONE_MIX, MIX_NEG_MAX);
    write_reg(REG_UNUSED, $urandom);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(-1);
    send_sample(SAMPLE_MAX);
    send_sample(1);
    drain_results();

    write_reg(REG_LONG_LENGTH, 4095);
    write_reg(REG_SHORT_LENGTH, 0);
    write_reg(REG_TREND_LENGTH, 0);
    write_reg(REG_LONG_RECIPROCAL, '0);
    write_reg(REG_SHORT_RECIPROCAL, RECIP_ONE);
    write_reg(REG_TREND_RECIPROCAL, RECIP_ONE);
    write_reg(REG_TONE_MIX, MIX_POS_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(1);
    send_sample('0);
    drain_results();
  endtask

  // A doubled short average with no long term drives the trend up to the limits of its range.
  task automatic test_trend_clipping();
    write_reg(REG_LONG_LENGTH, 1);
    write_reg(REG_SHORT_LENGTH, 1);
    write_reg(REG_TREND_LENGTH, 1);
    write_reg(REG_LONG_RECIPROCAL, '0);
    write_reg(REG_SHORT_RECIPROCAL, RECIP_MAX);
    write_reg(REG_TREND_RECIPROCAL, RECIP_ONE);
    write_reg(REG_TONE_MIX, MIX_POS_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    drain_results();
  endtask

  task automatic test_random_settings();
    int count;
    for (int phase = 0; phase < 8; phase++) begin
      configure_random(phase == 0 || $urandom_range(9) < 7);
      count = $urandom_range(60, 110);
      repeat (count) send_sample(next_sample());
      drain_results();
    end
  endtask

  // Long windows: enough requests for the oldest samples to leave both sums
  // and for the trend history to wrap many times.
  task automatic test_long_windows();
    int long_n;
    int short_n;
    long_n = HISTORY_DEPTH / 2;
    write_reg(REG_LONG_LENGTH, long_n);
    write_reg(REG_SHORT_LENGTH, $urandom_range(long_n / 2, long_n));
    write_reg(REG_TREND_LENGTH, TREND_DEPTH);
    short_n = window_len(short_len_reg, HISTORY_DEPTH);
    write_reg(REG_LONG_RECIPROCAL, (int'(RECIP_ONE) + long_n / 2) / long_n);
    write_reg(REG_SHORT_RECIPROCAL, (int'(RECIP_ONE) + short_n / 2) / short_n);
    write_reg(REG_TREND_RECIPROCAL, (int'(RECIP_ONE) + TREND_DEPTH / 2) / TREND_DEPTH);
    write_reg(REG_TONE_MIX, pick_mix());
    no_idle = 1'b1;
    repeat (800) send_sample(next_sample());
    no_idle = 1'b0;
    repeat (500) send_sample(next_sample());
    drain_results();
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_out.size() == 0) begin
        $error("out_sample: expected none, actual %0d", result_ch.out_sample);
        error_count++;
      end else begin
        want = expected_out.pop_front();
        if (result_ch.out_sample !== want) begin
          $error("out_sample: expected %0d, actual %0d", want, result_ch.out_sample);
          error_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((audio_ch.valid && audio_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    no_idle            = 1'b0;
    error_count        = 0;
    audio_ch.valid     = 1'b0;
    audio_ch.in_sample = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_trend_clipping();
    test_random_settings();
    test_long_windows();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_out.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cbtf_pkg.sv
src/cbtf_if.sv
src/cbtf_ram.sv
src/cbtf_ctrl.sv
src/cbtf_dp.sv
src/cascaded_boxcar_tone_filter.sv
tb/cascaded_boxcar_tone_filter_tb.sv
